/* rtl/sdspi_pkg.sv */
// Package for the SPI-mode SD card host sequencer.
// Holds sequencer state codes, command codes, constants and beat types.
// No dependencies.
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_TRAIN      = 4'd1,
    ST_DESEL      = 4'd2,
    ST_SEL        = 4'd3,
    ST_FRAME      = 4'd4,
    ST_POLL       = 4'd5,
    ST_REPLY      = 4'd6,
    ST_TRAIL      = 4'd7,
    ST_FAIL_TRAIL = 4'd8,
    ST_TOKEN      = 4'd9,
    ST_DATA       = 4'd10,
    ST_CRC        = 4'd11
  } seq_state_t;

  typedef enum logic [1:0] {
    MODE_INIT = 2'd0,
    MODE_READ = 2'd1,
    MODE_BYTE = 2'd2,
    MODE_TICK = 2'd3
  } mode_t;

  localparam logic [1:0] REG_INIT_TO  = 2'd0;
  localparam logic [1:0] REG_TOKEN_TO = 2'd1;
  localparam logic [1:0] REG_RETRIES  = 2'd2;
  localparam logic [1:0] REG_POLLS    = 2'd3;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_STOP      = 6'd12;
  localparam logic [5:0] CMD_READ_ONE  = 6'd17;
  localparam logic [5:0] CMD_READ_MULT = 6'd18;
  localparam logic [5:0] CMD_SEND_OP   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  localparam logic [7:0]  CRC_CMD0   = 8'h95;
  localparam logic [7:0]  CRC_CMD8   = 8'h87;
  localparam logic [7:0]  CRC_DUMMY  = 8'h01;
  localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS    = 32'h4000_0000;
  localparam logic [7:0]  TOKEN_DATA = 8'hFE;
  localparam logic [7:0]  R1_IDLE    = 8'h01;
  localparam logic [7:0]  R1_ILLEGAL = 8'h05;
  localparam logic [7:0]  BYTE_IDLE  = 8'hFF;
  localparam logic [15:0] ECHO_CMD8  = 16'h01AA;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic       xfer_valid;
    logic [7:0] tx_byte;
    logic       chip_select_low;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       done_res;
    logic       success;
    logic       high_capacity;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  idx;
    logic [15:0] data;
  } cfg_beat_t;

endpackage

/* rtl/sdspi_if.sv */
// Valid/ready channel interfaces for the SD SPI sequencer.
// Depends on sdspi_pkg for the beat types.
interface sdspi_in_if;
  logic                valid;
  logic                ready;
  sdspi_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdspi_out_if;
  logic                 valid;
  logic                 ready;
  sdspi_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sdspi_cfg_if;
  logic                 valid;
  logic                 ready;
  sdspi_pkg::cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sd_card_spi_init_and_read_unit.sv */
// SPI-mode SD card host sequencer: init and block read, one beat in per cycle while not stalled.
// A result beat, when the accepted input beat yields one, is registered and shown the cycle after acceptance.
// Throughput: one input beat per cycle; the output register stalls input only
// when it is full and not being taken.
// Reset: rst_n synchronous active low; state idle, registers at defaults except the result beat register.
// Depends on sdspi_pkg and the sdspi_*_if interfaces.
module sd_card_spi_init_and_read_unit #(
  parameter int CLOCK_TRAIN_BYTES = 10
) (
  input  logic clk,
  input  logic rst_n,
  sdspi_in_if.sink    in_ch,
  sdspi_out_if.source out_ch,
  sdspi_cfg_if.sink   cfg_ch
);
  localparam logic [9:0]  BLK_LAST    = 10'(sdspi_pkg::BLOCK_BYTES - 1);
  localparam logic [9:0]  TRAIN_END   = 10'(CLOCK_TRAIN_BYTES + 1);

  // configuration
  logic [15:0] init_to_r, token_to_r;
  logic [7:0]  retries_r, polls_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_to_r  <= 16'd1000;
      token_to_r <= 16'd100;
      retries_r  <= 8'd10;
      polls_r    <= 8'd10;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.idx)
        sdspi_pkg::REG_INIT_TO:  init_to_r  <= cfg_ch.data.data;
        sdspi_pkg::REG_TOKEN_TO: token_to_r <= cfg_ch.data.data;
        sdspi_pkg::REG_RETRIES:  retries_r  <= cfg_ch.data.data[7:0];
        sdspi_pkg::REG_POLLS:    polls_r    <= cfg_ch.data.data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  sdspi_pkg::seq_state_t st_r, st_nxt;
  logic [47:0] frame_r, frame_nxt;
  logic [9:0]  bc_r, bc_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] blocks_r, blocks_nxt;
  logic [31:0] reply_r, reply_nxt;
  logic [7:0]  r1_r, r1_nxt;
  logic        ba_r, ba_nxt;

  sdspi_pkg::out_beat_t ob_r, ob_nxt;
  logic                 ov_r, ov_nxt;

  logic accept;
  assign in_ch.ready = !ov_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  logic [5:0]  cmd;
  logic [7:0]  rx;
  logic [9:0]  bc_inc;
  logic        fin, fin_ok, emit, dv, dl;
  logic [31:0] addr;
  logic [2:0]  fidx;

  assign cmd    = frame_r[45:40];
  assign rx     = in_ch.data.rx_byte;
  assign bc_inc = bc_r + 10'd1;

  // next state, one pass per accepted beat
  always_comb begin
    st_nxt = st_r; frame_nxt = frame_r; bc_nxt = bc_r; retry_nxt = retry_r;
    tick_nxt = tick_r; blocks_nxt = blocks_r; reply_nxt = reply_r;
    r1_nxt = r1_r; ba_nxt = ba_r;
    fin = 1'b0; fin_ok = 1'b0; emit = 1'b0; dv = 1'b0; dl = 1'b0;
    addr = ba_r ? in_ch.data.sector : {in_ch.data.sector[22:0], 9'd0};
    if (accept) begin
      case (in_ch.data.mode)
        sdspi_pkg::MODE_TICK: begin
          if (tick_r != 16'hFFFF) tick_nxt = tick_r + 16'd1;
        end
        sdspi_pkg::MODE_INIT: begin
          if (st_r == sdspi_pkg::ST_IDLE) begin
            emit = 1'b1; ba_nxt = 1'b0; bc_nxt = '0; st_nxt = sdspi_pkg::ST_TRAIN;
          end
        end
        sdspi_pkg::MODE_READ: begin
          if (st_r == sdspi_pkg::ST_IDLE) begin
            emit = 1'b1;
            if (in_ch.data.block_count == 16'd0) fin = 1'b1;
            else begin
              blocks_nxt = in_ch.data.block_count;
              frame_nxt = {2'b01, (in_ch.data.block_count == 16'd1) ?
                           sdspi_pkg::CMD_READ_ONE : sdspi_pkg::CMD_READ_MULT,
                           addr, sdspi_pkg::CRC_DUMMY};
              bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
            end
          end
        end
        default: begin
          if (st_r != sdspi_pkg::ST_IDLE) begin
            emit = 1'b1;
            unique case (st_r)
              sdspi_pkg::ST_TRAIN: begin
                bc_nxt = bc_inc;
                if (bc_inc >= TRAIN_END) begin
                  retry_nxt = '0;
                  frame_nxt = {2'b01, sdspi_pkg::CMD_GO_IDLE, 32'd0, sdspi_pkg::CRC_CMD0};
                  bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
                end
              end
              sdspi_pkg::ST_DESEL: st_nxt = sdspi_pkg::ST_SEL;
              sdspi_pkg::ST_SEL: begin st_nxt = sdspi_pkg::ST_FRAME; bc_nxt = '0; end
              sdspi_pkg::ST_FRAME, sdspi_pkg::ST_POLL: begin
                logic resp;
                resp = 1'b0;
                bc_nxt = bc_inc;
                if (st_r == sdspi_pkg::ST_FRAME) begin
                  if (bc_inc >= 10'd6) begin
                    bc_nxt = '0;
                    if (polls_r == 8'd0) begin r1_nxt = 8'hFF; resp = 1'b1; end
                    else st_nxt = sdspi_pkg::ST_POLL;
                  end
                end else begin
                  r1_nxt = rx;
                  resp = !rx[7] || (bc_inc >= {2'b00, polls_r});
                end
                if (resp) begin
                  if (cmd == sdspi_pkg::CMD_IF_COND) begin
                    if (r1_nxt == sdspi_pkg::R1_IDLE) begin
                      st_nxt = sdspi_pkg::ST_REPLY; bc_nxt = '0; reply_nxt = '0;
                    end else if (r1_nxt == sdspi_pkg::R1_ILLEGAL) st_nxt = sdspi_pkg::ST_TRAIL;
                    else st_nxt = sdspi_pkg::ST_FAIL_TRAIL;
                  end else if (cmd == sdspi_pkg::CMD_READ_OCR) begin
                    if (r1_nxt == 8'd0) begin
                      st_nxt = sdspi_pkg::ST_REPLY; bc_nxt = '0; reply_nxt = '0;
                    end else st_nxt = sdspi_pkg::ST_FAIL_TRAIL;
                  end else if (cmd == sdspi_pkg::CMD_READ_ONE ||
                               cmd == sdspi_pkg::CMD_READ_MULT) begin
                    if (r1_nxt == 8'd0) begin st_nxt = sdspi_pkg::ST_TOKEN; tick_nxt = '0; end
                    else st_nxt = sdspi_pkg::ST_FAIL_TRAIL;
                  end else st_nxt = sdspi_pkg::ST_TRAIL;
                end
              end
              sdspi_pkg::ST_REPLY: begin
                reply_nxt = {reply_r[23:0], rx};
                bc_nxt = bc_inc;
                if (bc_inc >= 10'd4) st_nxt = sdspi_pkg::ST_TRAIL;
              end
              sdspi_pkg::ST_TRAIL: begin
                fin = 1'b0;
                case (cmd)
                  sdspi_pkg::CMD_GO_IDLE: begin
                    if (r1_r == sdspi_pkg::R1_IDLE) begin
                      frame_nxt = {2'b01, sdspi_pkg::CMD_IF_COND, sdspi_pkg::ARG_CMD8,
                                   sdspi_pkg::CRC_CMD8};
                      bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
                    end else begin
                      retry_nxt = retry_r + 8'd1;
                      if (retry_nxt >= retries_r) fin = 1'b1;
                      else begin
                        frame_nxt = {2'b01, sdspi_pkg::CMD_GO_IDLE, 32'd0,
                                     sdspi_pkg::CRC_CMD0};
                        bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
                      end
                    end
                  end
                  sdspi_pkg::CMD_IF_COND: begin
                    if ((r1_r == sdspi_pkg::R1_IDLE && reply_r[15:0] == sdspi_pkg::ECHO_CMD8)
                        || r1_r == sdspi_pkg::R1_ILLEGAL) begin
                      tick_nxt = '0;
                      retry_nxt = (r1_r == sdspi_pkg::R1_IDLE) ? 8'd1 : 8'd0;
                      frame_nxt = {2'b01, sdspi_pkg::CMD_APP, 32'd0, sdspi_pkg::CRC_DUMMY};
                      bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
                    end else fin = 1'b1;
                  end
                  sdspi_pkg::CMD_APP: begin
                    if (r1_r > 8'h01) fin = 1'b1;
                    else begin
                      frame_nxt = {2'b01, sdspi_pkg::CMD_SEND_OP,
                                   (retry_r != 8'd0) ? sdspi_pkg::ARG_HCS : 32'd0,
                                   sdspi_pkg::CRC_DUMMY};
                      bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
                    end
                  end
                  sdspi_pkg::CMD_SEND_OP: begin
                    if (r1_r == 8'd0) begin
                      if (retry_r != 8'd0) begin
                        frame_nxt = {2'b01, sdspi_pkg::CMD_READ_OCR, 32'd0,
                                     sdspi_pkg::CRC_DUMMY};
                        bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
                      end else begin fin = 1'b1; fin_ok = 1'b1; end
                    end else if (tick_r < init_to_r) begin
                      frame_nxt = {2'b01, sdspi_pkg::CMD_APP, 32'd0, sdspi_pkg::CRC_DUMMY};
                      bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
                    end else fin = 1'b1;
                  end
                  sdspi_pkg::CMD_READ_OCR: begin
                    ba_nxt = reply_r[30]; fin = 1'b1; fin_ok = 1'b1;
                  end
                  sdspi_pkg::CMD_READ_ONE, sdspi_pkg::CMD_STOP: begin
                    fin = 1'b1; fin_ok = 1'b1;
                  end
                  default: fin = 1'b1;
                endcase
              end
              sdspi_pkg::ST_FAIL_TRAIL: fin = 1'b1;
              sdspi_pkg::ST_TOKEN: begin
                if (rx == sdspi_pkg::TOKEN_DATA) begin
                  st_nxt = sdspi_pkg::ST_DATA; bc_nxt = '0;
                end else if (tick_r >= token_to_r) st_nxt = sdspi_pkg::ST_FAIL_TRAIL;
              end
              sdspi_pkg::ST_DATA: begin
                dv = 1'b1;
                dl = (blocks_r == 16'd1) && (bc_r == BLK_LAST);
                bc_nxt = bc_inc;
                if (bc_r == BLK_LAST) begin st_nxt = sdspi_pkg::ST_CRC; bc_nxt = '0; end
              end
              sdspi_pkg::ST_CRC: begin
                bc_nxt = bc_inc;
                if (bc_inc >= 10'd2) begin
                  blocks_nxt = blocks_r - 16'd1;
                  if (cmd == sdspi_pkg::CMD_READ_ONE) st_nxt = sdspi_pkg::ST_TRAIL;
                  else if (blocks_nxt != 16'd0) begin
                    st_nxt = sdspi_pkg::ST_TOKEN; tick_nxt = '0;
                  end else begin
                    frame_nxt = {2'b01, sdspi_pkg::CMD_STOP, 32'd0, sdspi_pkg::CRC_DUMMY};
                    bc_nxt = '0; st_nxt = sdspi_pkg::ST_DESEL;
                  end
                end
              end
              default: fin = 1'b1;
            endcase
          end
        end
      endcase
      if (fin) st_nxt = sdspi_pkg::ST_IDLE;
    end
  end

  // result beat from the next state
  always_comb begin
    fidx = 3'd0;
    case (bc_nxt[2:0])
      3'd1: fidx = 3'd1;
      3'd2: fidx = 3'd2;
      3'd3: fidx = 3'd3;
      3'd4: fidx = 3'd4;
      3'd5: fidx = 3'd5;
      default: fidx = 3'd0;
    endcase
    ob_nxt = '0;
    ob_nxt.high_capacity = ba_nxt;
    ob_nxt.data_valid = dv;
    ob_nxt.data_byte  = dv ? rx : 8'd0;
    ob_nxt.data_last  = dv && dl;
    if (fin) begin
      ob_nxt.done_res = 1'b1;
      ob_nxt.success  = fin_ok;
    end else begin
      ob_nxt.xfer_valid = 1'b1;
      ob_nxt.tx_byte    = sdspi_pkg::BYTE_IDLE;
      case (st_nxt)
        sdspi_pkg::ST_SEL, sdspi_pkg::ST_POLL, sdspi_pkg::ST_REPLY,
        sdspi_pkg::ST_TOKEN, sdspi_pkg::ST_DATA, sdspi_pkg::ST_CRC:
          ob_nxt.chip_select_low = 1'b1;
        sdspi_pkg::ST_FRAME: begin
          ob_nxt.chip_select_low = 1'b1;
          ob_nxt.tx_byte = frame_nxt[6'(40 - 8 * fidx) +: 8];
        end
        default: ob_nxt.chip_select_low = 1'b0;
      endcase
    end
    ov_nxt = emit ? 1'b1 : (ov_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sdspi_pkg::ST_IDLE; frame_r <= '0; bc_r <= '0; retry_r <= '0;
      tick_r <= '0; blocks_r <= '0; reply_r <= '0; r1_r <= 8'hFF; ba_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; frame_r <= frame_nxt; bc_r <= bc_nxt; retry_r <= retry_nxt;
      tick_r <= tick_nxt; blocks_r <= blocks_nxt; reply_r <= reply_nxt;
      r1_r <= r1_nxt; ba_r <= ba_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) ob_r <= ob_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = ob_r;

  // checks
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |-> !in_ch.ready) else $error("input taken over full output");
  a_done_no_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ob_r.done_res) |-> !ob_r.xfer_valid) else $error("done with exchange");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && fin) |=> (st_r == sdspi_pkg::ST_IDLE)) else $error("finish not idle");
  a_data_in_data_state: assert property (@(posedge clk) disable iff (!rst_n)
    dv |-> (st_r == sdspi_pkg::ST_DATA)) else $error("data outside block");

endmodule
